/* hdl/power_key_event_filter_defines.svh */
// assertion macros used by the checker file
`ifndef POWER_KEY_EVENT_FILTER_DEFINES_SVH
`define POWER_KEY_EVENT_FILTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PKEF_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication, checked outside reset
`define PKEF_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

/* hdl/pkef_pkg.sv */
`timescale 1ns / 1ps
package pkef_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_COMBO_WINDOW = 2'd1;
    localparam logic [1:0] REG_DOUBLE_PRESS = 2'd2;
    localparam logic [1:0] REG_DIRECT_OFF   = 2'd3;

    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] COMBO_WINDOW_RST = 16'd300;
    localparam logic [15:0] DOUBLE_PRESS_RST = 16'd700;

    // request kinds
    localparam logic ACTION_EVENT = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    // event classes
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_REL = 5'd2;
    localparam logic [4:0] EV_ABS = 5'd3;

    // key values
    localparam logic [1:0] KEY_UP     = 2'd0;
    localparam logic [1:0] KEY_DOWN   = 2'd1;
    localparam logic [1:0] KEY_REPEAT = 2'd2;

    // key codes
    localparam logic [9:0] CODE_POWER   = 10'd116;
    localparam logic [9:0] CODE_VOLDOWN = 10'd114;
    localparam logic [9:0] CODE_VOLUP   = 10'd115;
    localparam logic [9:0] CODE_CAMERA  = 10'd212;
    localparam logic [9:0] CODE_EXIT    = 10'd174;
    localparam logic [9:0] CODE_PHONE   = 10'd169;
    localparam logic [9:0] CODE_CONFIG  = 10'd171;
    localparam logic [9:0] CODE_SEARCH  = 10'd217;
    localparam logic [9:0] CODE_SCRLOCK = 10'h098;
    localparam logic [9:0] CODE_RSV_LO  = 10'h1DB;
    localparam logic [9:0] CODE_RSV_HI  = 10'h1DE;

    typedef enum logic [1:0] {
        COMBO_IDLE    = 2'd0,
        COMBO_FIRST   = 2'd1,
        COMBO_CAPTURE = 2'd2
    } t_combo_phase;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_POPUP    = 2'd1,
        ACT_POWEROFF = 2'd2
    } t_long_act;

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [15:0] combo_window_ticks;
        logic [15:0] double_press_ticks;
        logic        direct_poweroff;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [4:0] event_type;
        logic [9:0] key_code;
        logic [1:0] key_value;
        logic       display_on;
        logic       hold_blocked;
        logic       first_in_batch;
        logic       last_in_batch;
    } t_item;

    typedef struct packed {
        logic         ignore_verdict;
        logic         verdict_valid;
        logic         lcd_off_request;
        t_long_act    long_press_action;
        t_combo_phase combo_state;
    } t_result;

endpackage

/* hdl/pkef_cfg_regs.sv */
`timescale 1ns / 1ps
module pkef_cfg_regs
    import pkef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks   <= LONG_PRESS_RST;
            r_cfg.combo_window_ticks <= COMBO_WINDOW_RST;
            r_cfg.double_press_ticks <= DOUBLE_PRESS_RST;
            r_cfg.direct_poweroff    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LONG_PRESS:   r_cfg.long_press_ticks   <= i_cfg_data;
                REG_COMBO_WINDOW: r_cfg.combo_window_ticks <= i_cfg_data;
                REG_DOUBLE_PRESS: r_cfg.double_press_ticks <= i_cfg_data;
                REG_DIRECT_OFF:   r_cfg.direct_poweroff    <= i_cfg_data[0];
                default:          r_cfg                    <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/pkef_filter.sv */
`timescale 1ns / 1ps
module pkef_filter
    import pkef_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [31:0]  r_clock_now,        n_clock_now;
    logic [31:0]  r_last_press_time,  n_last_press_time;
    logic         r_press_seen,       n_press_seen;
    logic [15:0]  r_long_remaining,   n_long_remaining;
    logic         r_long_active,      n_long_active;
    logic [15:0]  r_combo_remaining,  n_combo_remaining;
    logic         r_combo_timer,      n_combo_timer;
    t_combo_phase r_combo_phase,      n_combo_phase;
    logic         r_cancel_lcd_off,   n_cancel_lcd_off;
    logic         r_power_suppressed, n_power_suppressed;
    logic         r_running_ignore,   n_running_ignore;

    logic [31:0] w_elapsed;
    logic        w_press_close;
    logic        w_held_long;
    logic        w_reserved;
    t_long_act   w_fire_act;

    assign w_elapsed     = r_clock_now - r_last_press_time;
    assign w_press_close = r_press_seen && (w_elapsed < {16'd0, i_cfg.double_press_ticks});
    assign w_held_long   = !r_press_seen || (w_elapsed > {16'd0, i_cfg.long_press_ticks});
    assign w_reserved    = (i_item.key_code == CODE_SCRLOCK) ||
                           ((i_item.key_code >= CODE_RSV_LO) && (i_item.key_code <= CODE_RSV_HI));
    assign w_fire_act    = i_cfg.direct_poweroff ? ACT_POWEROFF : ACT_POPUP;

    always_comb begin
        logic v_ign;
        n_clock_now        = r_clock_now;
        n_last_press_time  = r_last_press_time;
        n_press_seen       = r_press_seen;
        n_long_remaining   = r_long_remaining;
        n_long_active      = r_long_active;
        n_combo_remaining  = r_combo_remaining;
        n_combo_timer      = r_combo_timer;
        n_combo_phase      = r_combo_phase;
        n_cancel_lcd_off   = r_cancel_lcd_off;
        n_power_suppressed = r_power_suppressed;
        n_running_ignore   = r_running_ignore;
        v_ign              = 1'b1;
        o_result.verdict_valid     = 1'b0;
        o_result.lcd_off_request   = 1'b0;
        o_result.long_press_action = ACT_NONE;

        if (i_step) begin
            if (i_item.action == ACTION_TICK) begin
                n_clock_now = r_clock_now + 32'd1;
                if (r_long_active) begin
                    if (r_long_remaining <= 16'd1) begin
                        n_long_active    = 1'b0;
                        n_long_remaining = '0;
                        n_cancel_lcd_off = 1'b1;
                        o_result.long_press_action = w_fire_act;
                    end else begin
                        n_long_remaining = r_long_remaining - 16'd1;
                    end
                end
                if (r_combo_timer) begin
                    if (r_combo_remaining <= 16'd1) begin
                        n_combo_timer     = 1'b0;
                        n_combo_remaining = '0;
                        n_combo_phase     = COMBO_IDLE;
                    end else begin
                        n_combo_remaining = r_combo_remaining - 16'd1;
                    end
                end
            end else begin
                o_result.verdict_valid = i_item.last_in_batch;
                if (i_item.first_in_batch) begin
                    n_running_ignore = 1'b1;
                end
                if (i_item.event_type == EV_KEY) begin
                    // key events: a power or volume-down press opens the capture window or completes the combination
                    unique if (i_item.key_code == CODE_POWER) begin
                        unique case (i_item.key_value)
                            KEY_UP: begin
                                if (i_item.display_on && !r_cancel_lcd_off &&
                                    (r_combo_phase != COMBO_CAPTURE)) begin
                                    o_result.lcd_off_request = !i_item.hold_blocked;
                                end else begin
                                    v_ign = r_power_suppressed;
                                end
                                n_combo_phase     = COMBO_IDLE;
                                n_combo_timer     = 1'b0;
                                n_combo_remaining = '0;
                                n_cancel_lcd_off  = 1'b0;
                                n_long_active     = 1'b0;
                                n_long_remaining  = '0;
                            end
                            KEY_DOWN: begin
                                if (w_press_close) begin
                                    n_power_suppressed = 1'b1;
                                end else begin
                                    n_power_suppressed = 1'b0;
                                    n_last_press_time  = r_clock_now;
                                    n_press_seen       = 1'b1;
                                    unique case (r_combo_phase)
                                        COMBO_IDLE: begin
                                            n_long_remaining  = i_cfg.long_press_ticks;
                                            n_long_active     = 1'b1;
                                            n_combo_phase     = COMBO_FIRST;
                                            n_combo_remaining = i_cfg.combo_window_ticks;
                                            n_combo_timer     = 1'b1;
                                        end
                                        COMBO_FIRST: begin
                                            n_combo_timer     = 1'b0;
                                            n_combo_remaining = '0;
                                            n_combo_phase     = COMBO_CAPTURE;
                                            v_ign             = 1'b0;
                                        end
                                        default: v_ign = 1'b1;
                                    endcase
                                end
                            end
                            KEY_REPEAT: begin
                                if (w_held_long) begin
                                    n_cancel_lcd_off = 1'b1;
                                    o_result.long_press_action = w_fire_act;
                                end
                            end
                            default: v_ign = 1'b1;
                        endcase
                    end else if (i_item.key_code == CODE_VOLDOWN) begin
                        if (i_item.key_value == KEY_DOWN) begin
                            unique case (r_combo_phase)
                                COMBO_IDLE: begin
                                    n_combo_phase     = COMBO_FIRST;
                                    n_combo_remaining = i_cfg.combo_window_ticks;
                                    n_combo_timer     = 1'b1;
                                end
                                COMBO_FIRST: begin
                                    n_combo_timer     = 1'b0;
                                    n_combo_remaining = '0;
                                    n_combo_phase     = COMBO_CAPTURE;
                                    v_ign             = 1'b0;
                                end
                                default: v_ign = 1'b1;
                            endcase
                        end else if ((i_item.key_value == KEY_UP) &&
                                     (r_combo_phase != COMBO_CAPTURE)) begin
                            n_combo_phase     = COMBO_IDLE;
                            n_combo_timer     = 1'b0;
                            n_combo_remaining = '0;
                            v_ign             = !i_item.display_on;
                        end
                    end else if ((i_item.key_code == CODE_VOLUP)  ||
                                 (i_item.key_code == CODE_CAMERA) ||
                                 (i_item.key_code == CODE_EXIT)   ||
                                 (i_item.key_code == CODE_PHONE)  ||
                                 (i_item.key_code == CODE_CONFIG) ||
                                 (i_item.key_code == CODE_SEARCH)) begin
                        n_combo_phase     = COMBO_IDLE;
                        n_combo_timer     = 1'b0;
                        n_combo_remaining = '0;
                        v_ign             = !i_item.display_on;
                    end else begin
                        n_combo_phase     = COMBO_IDLE;
                        n_combo_timer     = 1'b0;
                        n_combo_remaining = '0;
                        v_ign             = w_reserved;
                    end
                    n_running_ignore = v_ign;
                end else if (i_item.event_type == EV_REL) begin
                    n_running_ignore = 1'b0;
                end else if ((i_item.event_type == EV_ABS) && i_item.display_on) begin
                    n_running_ignore = 1'b0;
                end
            end
        end

        o_result.ignore_verdict = n_running_ignore;
        o_result.combo_state    = n_combo_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_now        <= '0;
            r_last_press_time  <= '0;
            r_press_seen       <= 1'b0;
            r_long_remaining   <= '0;
            r_long_active      <= 1'b0;
            r_combo_remaining  <= '0;
            r_combo_timer      <= 1'b0;
            r_combo_phase      <= COMBO_IDLE;
            r_cancel_lcd_off   <= 1'b0;
            r_power_suppressed <= 1'b0;
            r_running_ignore   <= 1'b1;
        end else begin
            r_clock_now        <= n_clock_now;
            r_last_press_time  <= n_last_press_time;
            r_press_seen       <= n_press_seen;
            r_long_remaining   <= n_long_remaining;
            r_long_active      <= n_long_active;
            r_combo_remaining  <= n_combo_remaining;
            r_combo_timer      <= n_combo_timer;
            r_combo_phase      <= n_combo_phase;
            r_cancel_lcd_off   <= n_cancel_lcd_off;
            r_power_suppressed <= n_power_suppressed;
            r_running_ignore   <= n_running_ignore;
        end
    end

endmodule

/* hdl/power_key_event_filter.sv */
`timescale 1ns / 1ps
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// request   | in        | i_valid / o_stall          | action, event, key, batch flags
// result    | out       | o_valid / i_stall          | verdict, lcd off, long press, combo
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one request per cycle sustained while the result channel is not stalled; each accepted request passes
// through the request register, which feeds the filter update logic, which writes the result register
// synchronous active-low reset: timers and combo idle, verdict set to ignore, config defaults
// a stalled result holds the result register; the request register then stalls upstream
// config writes are always ready and land in the config registers
module power_key_event_filter
    import pkef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [4:0]  i_event_type,
    input  logic [9:0]  i_key_code,
    input  logic [1:0]  i_key_value,
    input  logic        i_display_on,
    input  logic        i_hold_blocked,
    input  logic        i_first_in_batch,
    input  logic        i_last_in_batch,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ignore_verdict,
    output logic        o_verdict_valid,
    output logic        o_lcd_off_request,
    output logic [1:0]  o_long_press_action,
    output logic [1:0]  o_combo_state,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_accept;

    assign o_cfg_ready = 1'b1;

    pkef_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // result register moves when empty or taken downstream
    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // request payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.action         <= i_action;
            r_in.event_type     <= i_event_type;
            r_in.key_code       <= i_key_code;
            r_in.key_value      <= i_key_value;
            r_in.display_on     <= i_display_on;
            r_in.hold_blocked   <= i_hold_blocked;
            r_in.first_in_batch <= i_first_in_batch;
            r_in.last_in_batch  <= i_last_in_batch;
        end
    end

    // filter state advances only when the held request moves into the result register
    pkef_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_ignore_verdict    = r_out.ignore_verdict;
    assign o_verdict_valid     = r_out.verdict_valid;
    assign o_lcd_off_request   = r_out.lcd_off_request;
    assign o_long_press_action = r_out.long_press_action;
    assign o_combo_state       = r_out.combo_state;

endmodule

/* hdl/pkef_checker.sv */
`timescale 1ns / 1ps
`include "power_key_event_filter_defines.svh"
module pkef_checker
    import pkef_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_ignore_verdict,
    input logic        o_verdict_valid,
    input logic        o_lcd_off_request,
    input logic [1:0]  o_long_press_action,
    input logic [1:0]  o_combo_state
);

    // the request side only stalls behind a full, stalled result register
    `PKEF_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall, "request stall without result stall")

    // a held result keeps its payload
    `PKEF_ASSERT_NEXT(a_result_hold, o_valid && i_stall, o_valid && $stable(o_ignore_verdict) && $stable(o_verdict_valid) && $stable(o_lcd_off_request) && $stable(o_long_press_action) && $stable(o_combo_state), "stalled result changed")

    // lcd off comes from a power release only: combo cleared, batch ignored, no long press
    `PKEF_ASSERT_NOW(a_lcd_off_release, o_valid && o_lcd_off_request, o_ignore_verdict && (o_combo_state == COMBO_IDLE) && (o_long_press_action == ACT_NONE), "lcd off request outside a power release")

endmodule

bind power_key_event_filter pkef_checker u_pkef_checker (.*);

/* tb/power_key_event_filter_tb.sv */
`timescale 1ns / 1ps
module power_key_event_filter_tb;
    import pkef_pkg::*;

    // key value outside the documented set: must leave state alone and ignore
    localparam logic [1:0] KEY_VALUE_UNUSED = 2'd3;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int HOLD_OFF_AFTER  = 300;

    // dut ports, all inputs known from time zero
    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic        o_stall;
    logic        i_action           = ACTION_EVENT;
    logic [4:0]  i_event_type       = '0;
    logic [9:0]  i_key_code         = '0;
    logic [1:0]  i_key_value        = KEY_UP;
    logic        i_display_on       = 1'b0;
    logic        i_hold_blocked     = 1'b0;
    logic        i_first_in_batch   = 1'b0;
    logic        i_last_in_batch    = 1'b0;
    logic        o_valid;
    logic        i_stall            = 1'b0;
    logic        o_ignore_verdict;
    logic        o_verdict_valid;
    logic        o_lcd_off_request;
    logic [1:0]  o_long_press_action;
    logic [1:0]  o_combo_state;
    logic        i_cfg_valid        = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index        = REG_LONG_PRESS;
    logic [15:0] i_cfg_data         = '0;

    // stimulus side
    t_item       key_requests[$];
    t_item       next_req;
    int          reqs_queued        = 0;
    int          send_idle_pct      = 0;
    int          tick_span          = 3;

    // receive side
    int          recv_stall_pct     = 0;
    int          hold_left          = 0;
    bit          long_hold_done     = 1'b0;

    // checking side
    t_result     expected_verdicts[$];
    t_result     wanted;
    t_item       seen_req;
    bit          req_fire           = 1'b0;
    int          reqs_accepted      = 0;
    int          results_seen       = 0;
    int          err_count          = 0;

    // shadow of the filter: config and state
    t_cfg         model_cfg;
    logic [31:0]  ms_clock;
    logic [31:0]  last_press_ms;
    logic         power_pressed_once;
    logic [15:0]  long_left;
    logic         long_running;
    logic [15:0]  combo_left;
    logic         combo_running;
    t_combo_phase combo_ph;
    logic         lcd_off_blocked;
    logic         press_dropped;
    logic         verdict_ignore;

    power_key_event_filter DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_action            (i_action),
        .i_event_type        (i_event_type),
        .i_key_code          (i_key_code),
        .i_key_value         (i_key_value),
        .i_display_on        (i_display_on),
        .i_hold_blocked      (i_hold_blocked),
        .i_first_in_batch    (i_first_in_batch),
        .i_last_in_batch     (i_last_in_batch),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_ignore_verdict    (o_ignore_verdict),
        .o_verdict_valid     (o_verdict_valid),
        .o_lcd_off_request   (o_lcd_off_request),
        .o_long_press_action (o_long_press_action),
        .o_combo_state       (o_combo_state),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // shadow filter
    // ------------------------------------------------------------------

    function automatic void model_reset();
        model_cfg.long_press_ticks   = LONG_PRESS_RST;
        model_cfg.combo_window_ticks = COMBO_WINDOW_RST;
        model_cfg.double_press_ticks = DOUBLE_PRESS_RST;
        model_cfg.direct_poweroff    = 1'b0;
        ms_clock           = '0;
        last_press_ms      = '0;
        power_pressed_once = 1'b0;
        long_left          = '0;
        long_running       = 1'b0;
        combo_left         = '0;
        combo_running      = 1'b0;
        combo_ph           = COMBO_IDLE;
        lcd_off_blocked    = 1'b0;
        press_dropped      = 1'b0;
        verdict_ignore     = 1'b1;
    endfunction

    function automatic void combo_cancel();
        combo_ph      = COMBO_IDLE;
        combo_running = 1'b0;
        combo_left    = '0;
    endfunction

    // long press reached: a later release must not blank the lcd
    function automatic t_long_act long_press_fire();
        lcd_off_blocked = 1'b1;
        return model_cfg.direct_poweroff ? ACT_POWEROFF : ACT_POPUP;
    endfunction

    // one key of the capture combination went down, returns the ignore verdict
    function automatic logic combo_key_down();
        if (combo_ph == COMBO_IDLE) begin
            combo_ph      = COMBO_FIRST;
            combo_left    = model_cfg.combo_window_ticks;
            combo_running = 1'b1;
        end else if (combo_ph == COMBO_FIRST) begin
            combo_running = 1'b0;
            combo_left    = '0;
            combo_ph      = COMBO_CAPTURE;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_result filter_step(t_item req);
        t_result     res;
        logic [31:0] since_press;
        logic        ign;
        res = '0;
        if (req.action == ACTION_TICK) begin
            ms_clock = ms_clock + 32'd1;
            // both timers may run out on the same tick
            if (long_running) begin
                if (long_left <= 16'd1) begin
                    long_running          = 1'b0;
                    long_left             = '0;
                    res.long_press_action = long_press_fire();
                end else begin
                    long_left = long_left - 16'd1;
                end
            end
            if (combo_running) begin
                if (combo_left <= 16'd1) begin
                    combo_running = 1'b0;
                    combo_left    = '0;
                    combo_ph      = COMBO_IDLE;
                end else begin
                    combo_left = combo_left - 16'd1;
                end
            end
        end else begin
            if (req.first_in_batch)
                verdict_ignore = 1'b1;
            res.verdict_valid = req.last_in_batch;
            if (req.event_type == EV_KEY) begin
                ign = 1'b1;
                case (req.key_code)
                    CODE_POWER: begin
                        // modular distance to the last accepted press
                        since_press = ms_clock - last_press_ms;
                        case (req.key_value)
                            KEY_UP: begin
                                if (req.display_on && !lcd_off_blocked &&
                                    combo_ph != COMBO_CAPTURE) begin
                                    if (!req.hold_blocked)
                                        res.lcd_off_request = 1'b1;
                                end else if (!press_dropped) begin
                                    ign = 1'b0;
                                end
                                combo_cancel();
                                lcd_off_blocked = 1'b0;
                                long_running    = 1'b0;
                                long_left       = '0;
                            end
                            KEY_DOWN: begin
                                if (power_pressed_once &&
                                    since_press < {16'd0, model_cfg.double_press_ticks}) begin
                                    press_dropped = 1'b1;
                                end else begin
                                    press_dropped      = 1'b0;
                                    last_press_ms      = ms_clock;
                                    power_pressed_once = 1'b1;
                                    if (combo_ph == COMBO_IDLE) begin
                                        long_left    = model_cfg.long_press_ticks;
                                        long_running = 1'b1;
                                    end
                                    ign = combo_key_down();
                                end
                            end
                            KEY_REPEAT: begin
                                // with no press yet the key counts as held long enough
                                if (!power_pressed_once ||
                                    since_press > {16'd0, model_cfg.long_press_ticks})
                                    res.long_press_action = long_press_fire();
                            end
                            default: ;
                        endcase
                    end
                    CODE_VOLDOWN: begin
                        if (req.key_value == KEY_DOWN) begin
                            ign = combo_key_down();
                        end else if (req.key_value == KEY_UP &&
                                     combo_ph != COMBO_CAPTURE) begin
                            combo_cancel();
                            ign = !req.display_on;
                        end
                    end
                    CODE_VOLUP, CODE_CAMERA, CODE_EXIT, CODE_PHONE, CODE_CONFIG,
                    CODE_SEARCH: begin
                        combo_cancel();
                        ign = !req.display_on;
                    end
                    default: begin
                        combo_cancel();
                        ign = (req.key_code == CODE_SCRLOCK) ||
                              (req.key_code >= CODE_RSV_LO && req.key_code <= CODE_RSV_HI);
                    end
                endcase
                verdict_ignore = ign;
            end else if (req.event_type == EV_REL) begin
                verdict_ignore = 1'b0;
            end else if (req.event_type == EV_ABS && req.display_on) begin
                verdict_ignore = 1'b0;
            end
        end
        res.ignore_verdict = verdict_ignore;
        res.combo_state    = combo_ph;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request construction
    // ------------------------------------------------------------------

    // flags: {display_on, hold_blocked, first_in_batch, last_in_batch}
    function automatic t_item key_req(logic [4:0] etype, logic [9:0] code, logic [1:0] val,
                                      logic [3:0] flags);
        t_item req;
        req.action     = ACTION_EVENT;
        req.event_type = etype;
        req.key_code   = code;
        req.key_value  = val;
        {req.display_on, req.hold_blocked, req.first_in_batch, req.last_in_batch} = flags;
        return req;
    endfunction

    function automatic logic [3:0] rand_flags();
        return 4'($urandom_range(0, 15));
    endfunction

    // event fields of a tick carry random junk, the filter must not look at them
    function automatic t_item tick_req();
        t_item req;
        req = key_req(5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                      2'($urandom_range(0, 2)), rand_flags());
        req.action = ACTION_TICK;
        return req;
    endfunction

    // keys outside the power / volume-down pair
    function automatic logic [9:0] side_code(int k);
        case (k)
            0:       return CODE_VOLUP;
            1:       return CODE_CAMERA;
            2:       return CODE_EXIT;
            3:       return CODE_PHONE;
            4:       return CODE_CONFIG;
            5:       return CODE_SEARCH;
            6:       return CODE_SCRLOCK;
            7:       return CODE_RSV_LO;
            8:       return CODE_RSV_HI;
            default: return CODE_RSV_LO + 10'd1;
        endcase
    endfunction

    function automatic logic [9:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return CODE_POWER;
        if (r < 5)
            return CODE_VOLDOWN;
        if (r < 8)
            return side_code($urandom_range(0, 9));
        return 10'($urandom_range(0, 767));
    endfunction

    task automatic queue_item(t_item req);
        key_requests.push_back(req);
        reqs_queued++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_item(tick_req());
    endtask

    // one burst of random traffic: mostly well formed key gestures
    task automatic queue_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            // power press and hold, maybe joined by volume-down
            queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, rand_flags()));
            queue_ticks($urandom_range(0, tick_span));
            if ($urandom_range(0, 1))
                queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_DOWN, rand_flags()));
            if ($urandom_range(0, 2) == 0)
                queue_item(key_req(EV_KEY, CODE_POWER, KEY_REPEAT, rand_flags()));
            queue_ticks($urandom_range(0, tick_span));
            if ($urandom_range(0, 2) != 0)
                queue_item(key_req(EV_KEY, CODE_POWER, KEY_REPEAT, rand_flags()));
            queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, rand_flags()));
            if ($urandom_range(0, 1))
                queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_UP, rand_flags()));
        end else if (pick < 65) begin
            // volume-down first, power inside or outside the window
            queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_DOWN, rand_flags()));
            queue_ticks($urandom_range(0, tick_span));
            queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, rand_flags()));
            queue_ticks($urandom_range(0, tick_span));
            queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_UP, rand_flags()));
            queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, rand_flags()));
        end else if (pick < 80) begin
            queue_ticks($urandom_range(1, tick_span));
        end else begin
            // noise: any class, any key
            queue_item(key_req($urandom_range(0, 1) ? EV_KEY : 5'($urandom_range(0, 31)),
                               pick_code(), 2'($urandom_range(0, 2)), rand_flags()));
        end
    endtask

    task automatic queue_random(int n);
        int start;
        start = reqs_queued;
        while (reqs_queued - start < n)
            queue_burst();
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // configuration and phase control
    // ------------------------------------------------------------------

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] long_ms, logic [15:0] combo_ms,
                              logic [15:0] double_ms, logic direct_off);
        write_reg(REG_LONG_PRESS, long_ms);
        write_reg(REG_COMBO_WINDOW, combo_ms);
        write_reg(REG_DOUBLE_PRESS, double_ms);
        write_reg(REG_DIRECT_OFF, {15'd0, direct_off});
    endtask

    // every request taken and every verdict back, then a quiet settling wait
    task automatic wait_drained();
        int spins;
        while (reqs_accepted != reqs_queued)
            @(negedge i_clk);
        spins = 0;
        while (expected_verdicts.size() != 0 && spins < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spins++;
        end
        if (expected_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
            expected_verdicts.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // request driver: pops the queue at the falling edge, holds while stalled
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_fire) begin
            if (key_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = key_requests.pop_front();
                i_valid  <= 1'b1;
                {i_action, i_event_type, i_key_code, i_key_value, i_display_on,
                 i_hold_blocked, i_first_in_batch, i_last_in_batch} <= next_req;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result stall: random, plus one long hold-off so the pipe fills and pushes back
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= HOLD_OFF_AFTER) begin
            i_stall        <= 1'b1;
            hold_left      <= HOLD_OFF_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: config mirror, result check, then prediction of new requests
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_fire = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LONG_PRESS:   model_cfg.long_press_ticks   = i_cfg_data;
                    REG_COMBO_WINDOW: model_cfg.combo_window_ticks = i_cfg_data;
                    REG_DOUBLE_PRESS: model_cfg.double_press_ticks = i_cfg_data;
                    REG_DIRECT_OFF:   model_cfg.direct_poweroff    = i_cfg_data[0];
                endcase
            end
            // check before predicting so a stray result never meets its own request
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              results_seen));
                end else begin
                    wanted = expected_verdicts.pop_front();
                    check_field("ignore_verdict", {1'b0, o_ignore_verdict},
                                {1'b0, wanted.ignore_verdict});
                    check_field("verdict_valid", {1'b0, o_verdict_valid},
                                {1'b0, wanted.verdict_valid});
                    check_field("lcd_off_request", {1'b0, o_lcd_off_request},
                                {1'b0, wanted.lcd_off_request});
                    check_field("long_press_action", o_long_press_action,
                                wanted.long_press_action);
                    check_field("combo_state", o_combo_state, wanted.combo_state);
                end
            end
            req_fire = i_valid && !o_stall;
            if (req_fire) begin
                seen_req = {i_action, i_event_type, i_key_code, i_key_value, i_display_on,
                            i_hold_blocked, i_first_in_batch, i_last_in_batch};
                expected_verdicts.push_back(filter_step(seen_req));
                reqs_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        model_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, sender mostly busy, receiver mostly stalled
        send_idle_pct  = 20;
        recv_stall_pct = 74;
        tick_span      = 25;
        // repeat with no press yet counts as a long hold
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_REPEAT, 4'b1011));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, 4'b1001));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b1010));
        // second press inside the double-press window is dropped
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b1001));
        queue_item(tick_req());
        // volume-down completes the capture combination
        queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_DOWN, 4'b1011));
        queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_REPEAT, 4'b0011));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_VALUE_UNUSED, 4'b1101));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, 4'b1000));
        queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_UP, 4'b1011));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b0011));
        // release with the hold lock on: no lcd off
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, 4'b1111));
        queue_item(key_req(EV_REL, CODE_POWER, KEY_DOWN, 4'b0010));
        queue_item(key_req(EV_ABS, 10'd0, KEY_UP, 4'b0010));
        queue_item(key_req(EV_ABS, 10'd767, KEY_REPEAT, 4'b1000));
        // unknown classes leave the verdict alone; only a batch start resets it
        queue_item(key_req(5'd0, 10'd0, KEY_UP, 4'b0000));
        queue_item(key_req(5'd31, 10'd767, KEY_REPEAT, 4'b1111));
        for (int k = 0; k < 10; k++)
            queue_item(key_req(EV_KEY, side_code(k), KEY_DOWN, {k[0], 1'b0, 1'b0, 1'b1}));
        queue_random(400);
        wait_drained();

        // shortest timers, no double-press window, direct power off
        set_config(16'd1, 16'd1, 16'd0, 1'b1);
        send_idle_pct  = 74;
        recv_stall_pct = 20;
        tick_span      = 3;
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b1011));
        // long press and combination window run out on the same tick
        queue_item(tick_req());
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, 4'b1001));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b1001));
        queue_item(key_req(EV_KEY, CODE_VOLDOWN, KEY_UP, 4'b1001));
        // press while the long timer runs reloads it
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b1001));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_REPEAT, 4'b1001));
        queue_ticks(3);
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_REPEAT, 4'b1001));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, 4'b1001));
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_DOWN, 4'b1011));
        // plain short press and release with display on asks for lcd off
        queue_item(key_req(EV_KEY, CODE_POWER, KEY_UP, 4'b1001));
        queue_random(450);
        wait_drained();

        // longest timers and window, popup on long press, no idling
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tick_span      = 20;
        queue_random(200);
        wait_drained();

        // a few random mid-range settings
        for (int p = 0; p < 3; p++) begin
            tick_span = $urandom_range(2, 25);
            set_config(16'(tick_span), 16'($urandom_range(2, 25)),
                       16'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
            tick_span = tick_span + 5;
            queue_random(220);
            wait_drained();
        end

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pkef_pkg.sv
hdl/pkef_cfg_regs.sv
hdl/pkef_filter.sv
hdl/power_key_event_filter.sv
hdl/pkef_checker.sv
tb/power_key_event_filter_tb.sv
